FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define RTCDEC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtcdec assertion failed");

// Check that cons holds in the cycle after ante holds.
`define RTCDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcdec assertion failed");

`endif

FILE: design/rtcdec_pkg.sv
// Types and constants of the BCD clock snapshot decoder.
`default_nettype none

package rtcdec_pkg;

    // Raw clock registers, seconds in the lowest byte.
    typedef struct packed {
        logic [7:0] year_byte;
        logic [7:0] month_byte;
        logic [7:0] day_byte;
        logic [7:0] hours_byte;
        logic [7:0] minutes_byte;
        logic [7:0] seconds_byte;
    } rtcdec_raw_t;

    // Decoded result, packed time in the lowest bits.
    typedef struct packed {
        logic [7:0]  fault_bits;
        logic        time_valid;
        logic [31:0] packed_time;
    } rtcdec_result_t;

    localparam int unsigned RawWidth    = $bits(rtcdec_raw_t);
    localparam int unsigned ResultWidth = $bits(rtcdec_result_t);
    localparam int unsigned OutWidth    = ((ResultWidth + 7) / 8) * 8;

    localparam logic [31:0] TIME_INVALID = 32'hffff_ffff;
    localparam logic [31:0] WINDOW_LOW   = {6'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
    localparam logic [31:0] WINDOW_HIGH  = {6'd63, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};

    localparam int unsigned FAULT_RANGE = 6;
    localparam int unsigned FAULT_LOWV  = 7;

    // Days in each month, February allowing the 29th.
    function automatic logic [4:0] month_days(input logic [3:0] mo);
        logic [4:0] d;
        begin
            case (mo)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
                4'd2:                                       d = 5'd29;
                default:                                    d = 5'd0;
            endcase
            return d;
        end
    endfunction

    function automatic logic bcd_bad(input logic [7:0] v);
        return (v > 8'h99) || (v[3:0] > 4'd9);
    endfunction

    // high*10 + low, at most 165.
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
    endfunction

endpackage

`default_nettype wire

FILE: design/rtcdec_core.sv
// Combinational decode and validation of one clock snapshot.
`default_nettype none

module rtcdec_core
    import rtcdec_pkg::*;
(
    input  wire logic           present,
    input  wire rtcdec_raw_t    raw,
    output rtcdec_result_t      result
);

    logic [7:0]  sec_m, min_m, hr_m, day_m, mon_m, yr_m;
    logic [7:0]  sec_b, min_b, hr_b, day_b, mon_b, yr_b;
    logic [7:0]  yr_mod;
    logic [31:0] t;
    logic [7:0]  fault;
    logic        date_bad;
    logic        window_bad;

    always_comb
    begin
        // Strip the bits that carry no time digits.
        sec_m = {1'b0, raw.seconds_byte[6:0]};
        min_m = {1'b0, raw.minutes_byte[6:0]};
        hr_m  = {2'b00, raw.hours_byte[5:0]};
        day_m = {2'b00, raw.day_byte[5:0]};
        mon_m = {3'b000, raw.month_byte[4:0]};
        yr_m  = raw.year_byte;

        sec_b = bcd_value(sec_m);
        min_b = bcd_value(min_m);
        hr_b  = bcd_value(hr_m);
        day_b = bcd_value(day_m);
        mon_b = bcd_value(mon_m);
        yr_b  = bcd_value(yr_m);

        // Year below 200, so one subtract reduces it mod 100.
        yr_mod = (yr_b >= 8'd100) ? (yr_b - 8'd100) : yr_b;

        t = {yr_mod[5:0], mon_b[3:0], day_b[4:0], hr_b[4:0], min_b[5:0], sec_b[5:0]};

        fault    = 8'd0;
        fault[0] = bcd_bad(sec_m);
        fault[1] = bcd_bad(min_m);
        fault[2] = bcd_bad(hr_m);
        fault[3] = bcd_bad(day_m);
        fault[4] = bcd_bad(mon_m);
        fault[5] = bcd_bad(yr_m);
        fault[FAULT_LOWV] = raw.seconds_byte[7];

        date_bad = (t[25:22] == 4'd0) || (t[25:22] > 4'd12)
                || (t[21:17] == 5'd0) || (t[21:17] > month_days(t[25:22]))
                || ((t[25:22] == 4'd2) && (t[21:17] == 5'd29) && (t[27:26] != 2'b00))
                || (t[16:12] > 5'd23) || (t[11:6] > 6'd59) || (t[5:0] > 6'd59);
        window_bad = (t <= WINDOW_LOW) || (t > WINDOW_HIGH) || (yr_mod > 8'd63);
        fault[FAULT_RANGE] = date_bad || window_bad;

        if (!present)
        begin
            result.packed_time = TIME_INVALID;
            result.time_valid  = 1'b0;
            result.fault_bits  = 8'd0;
        end
        else
        begin
            result.packed_time = (fault != 8'd0) ? TIME_INVALID : t;
            result.time_valid  = (fault == 8'd0);
            result.fault_bits  = fault;
        end
    end

endmodule

`default_nettype wire

FILE: design/rtc_bcd_time_decode_validate.sv
// A transfer passes an input register, then a result register that drives m_tvalid.
// Throughput: one item per cycle unless m_tready stalls; the two registers part the two sides.
// The decode between them is a single pass of BCD conversion, compares and table lookup.
// Reset: rst_n, asynchronous, active low, empties both registers and clears device_present.
// Configuration: cfg_ready stays high; write cfg_data only while no item is in flight.
`default_nettype none

module rtc_bcd_time_decode_validate
    import rtcdec_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write channel.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [0:0]           cfg_data,     // bit 0: device_present
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // From bit 0 up: seconds_byte, minutes_byte, hours_byte, day_byte,
    // month_byte, year_byte (8 bits each).
    input  wire logic [RawWidth-1:0]  s_tdata,
    // Output stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // From bit 0 up: packed_time (32), time_valid (1), fault_bits (8), zero pad.
    output logic [OutWidth-1:0]       m_tdata
);

    logic           present_reg;
    logic           in_valid_reg, in_valid_next;
    rtcdec_raw_t    in_data_reg;
    logic           out_valid_reg, out_valid_next;
    rtcdec_result_t out_data_reg;
    rtcdec_result_t core_result;
    logic           out_load;
    logic           in_load;

    // Advance the result register when empty or being drained.
    assign out_load  = !out_valid_reg || m_tready;
    // Take a new transfer whenever the input register is empty or moves on.
    assign s_tready  = !in_valid_reg || out_load;
    assign in_load   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    rtcdec_core u_core
    (
        .present (present_reg),
        .raw     (in_data_reg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                present_reg <= cfg_data[0];
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold unless their stage advances.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= rtcdec_raw_t'(s_tdata);
        end
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutWidth - ResultWidth){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

FILE: design/rtcdec_checker.sv
// Port-level checker for the clock snapshot decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rtcdec_checker
    import rtcdec_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [OutWidth-1:0] m_tdata
);

    // A stalled result holds.
    `RTCDEC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A valid time carries no fault.
    `RTCDEC_ASSERT_SAME(a_valid_no_fault, clk, rst_n, m_tvalid && m_tdata[32], m_tdata[40:33] == 8'd0)

    // An invalid result always shows the all-ones time.
    `RTCDEC_ASSERT_SAME(a_invalid_ones, clk, rst_n, m_tvalid && !m_tdata[32], m_tdata[31:0] == TIME_INVALID)

    // A valid time has a real month and day.
    `RTCDEC_ASSERT_SAME(a_valid_month, clk, rst_n, m_tvalid && m_tdata[32], (m_tdata[25:22] != 4'd0) && (m_tdata[25:22] <= 4'd12) && (m_tdata[21:17] != 5'd0))

endmodule

bind rtc_bcd_time_decode_validate rtcdec_checker u_rtcdec_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
